### rtl/core/gwm_pkg.sv
// shared types, character codes and case folding for the glob matcher
package gwm_pkg;

  localparam logic [7:0] CH_ANY  = 8'h3F;  // '?'
  localparam logic [7:0] CH_STAR = 8'h2A;  // '*'
  localparam logic [7:0] CH_UA   = 8'h41;  // 'A'
  localparam logic [7:0] CH_UZ   = 8'h5A;  // 'Z'
  localparam logic [7:0] CH_LA   = 8'h61;  // 'a'

  localparam logic REQ_PATTERN = 1'b0;
  localparam logic REQ_TEXT    = 1'b1;

  // one text step as seen by the nfa
  typedef struct packed {
    logic       fresh;    // first text item: start from position zero
    logic       consume;  // item carries a byte
    logic [7:0] ch;       // text byte
  } gwm_step_t;

  function automatic logic [7:0] fold_char(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CH_UA && c <= CH_UZ) begin
      r = c - CH_UA + CH_LA;
    end
    return r;
  endfunction

endpackage

### rtl/core/gwm_nfa.sv
// next position set of the glob nfa for one text item
module gwm_nfa #(
  parameter int MAX_PATTERN = 32
) (
  input  logic [MAX_PATTERN:0]   cur_set,
  input  logic [MAX_PATTERN-1:0] pat_star,
  input  logic [MAX_PATTERN-1:0] pat_any,
  input  logic [7:0]             pat_fold [MAX_PATTERN],
  input  logic [MAX_PATTERN-1:0] pat_valid,
  input  gwm_pkg::gwm_step_t     step,
  output logic [MAX_PATTERN:0]   nxt_set
);
  import gwm_pkg::*;

  localparam int N   = MAX_PATTERN;
  localparam int LVL = (N > 1) ? $clog2(N + 1) : 1;

  // reached star positions also reach the next position; parallel prefix over runs of stars
  function automatic logic [N:0] closure(input logic [N:0] s, input logic [N-1:0] prop);
    logic [N:0] g;
    logic [N:0] p;
    logic [N:0] gn;
    logic [N:0] pn;
    int         d;
    g    = s;
    p    = '0;
    p[N:1] = prop;
    for (int l = 0; l < LVL; l++) begin
      d = 1 << l;
      for (int j = 0; j <= N; j++) begin
        if (j >= d) begin
          gn[j] = g[j] | (p[j] & g[j-d]);
          pn[j] = p[j] & p[j-d];
        end else begin
          gn[j] = g[j];
          pn[j] = p[j];
        end
      end
      g = gn;
      p = pn;
    end
    return g;
  endfunction

  logic [N-1:0] prop;
  logic [N:0]   start_set;
  logic [N:0]   stepped;
  logic [7:0]   text_fold;
  logic [N:0]   seed;

  assign prop      = pat_valid & pat_star;
  assign text_fold = fold_char(step.ch);
  assign seed      = {{N{1'b0}}, 1'b1};
  assign start_set = step.fresh ? closure(seed, prop) : cur_set;

  always_comb begin
    stepped = '0;
    for (int i = 0; i < N; i++) begin
      if (start_set[i] && pat_valid[i]) begin
        if (pat_star[i]) begin
          stepped[i] = 1'b1;
        end else if (pat_any[i] || pat_fold[i] == text_fold) begin
          stepped[i+1] = 1'b1;
        end
      end
    end
  end

  assign nxt_set = step.consume ? closure(stepped, prop) : start_set;

endmodule

### rtl/core/glob_wildcard_matcher.sv
// case-insensitive glob matcher: stores a pattern, streams text, reports a match per text
// Pattern and text bytes arrive on the slave stream, one transaction per cycle with no
// bubbles unless the slave side stalls; each is taken into an input register, and from it
// the whole position set of the nfa (every pattern position at once, star runs followed by
// a prefix network) is updated in the position set register and, for a text transaction
// marked last, the verdict is loaded into the result register. Pattern bytes beyond
// MAX_PATTERN are dropped, flagged as overflow, and force a mismatch. The slave side keeps
// accepting while a result waits, and stalls only when a second result is ready before the
// first has been taken.
module glob_wildcard_matcher #(
  parameter int MAX_PATTERN = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // char_in
  input  logic [1:0] s_tuser,   // req_type, no_char
  input  logic       s_tlast,   // last
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // matched, pattern_overflow, zero fill
);
  import gwm_pkg::*;

  localparam int N     = MAX_PATTERN;
  localparam int LEN_W = $clog2(N + 1);
  localparam int IDX_W = (N > 1) ? $clog2(N) : 1;

  // input register
  logic       in_valid;
  logic       in_req;
  logic [7:0] in_ch;
  logic       in_none;
  logic       in_last;

  // matcher state
  logic [LEN_W-1:0] length;
  logic [LEN_W-1:0] length_next;
  logic             closed;
  logic             ovf;
  logic             ovf_next;
  logic             text_open;
  logic [N:0]       pos_set;
  logic [N:0]       pos_next;
  logic [N-1:0]     pat_star;
  logic [N-1:0]     pat_any;
  logic [7:0]       pat_fold [N];
  logic [N-1:0]     pat_valid;

  // result register
  logic out_valid;
  logic out_matched;
  logic out_ovf;

  logic             emits;
  logic             advance;
  logic [LEN_W-1:0] len_base;
  logic             full;
  logic             store;
  gwm_step_t        step;

  assign emits    = (in_req == REQ_TEXT) && in_last;
  assign advance  = in_valid && (!emits || !out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_req  <= s_tuser[0];
      in_ch   <= s_tdata;
      in_none <= s_tuser[1];
      in_last <= s_tlast;
    end
  end

  // pattern side: a transaction after a closed pattern starts over
  assign len_base = closed ? '0 : length;
  assign full     = (len_base == LEN_W'(N));
  assign store    = !in_none && !full;

  always_comb begin
    length_next = len_base;
    if (store) begin
      length_next = len_base + LEN_W'(1);
    end
    ovf_next = (closed ? 1'b0 : ovf) | (!in_none && full);
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      pat_valid[i] = (length > LEN_W'(i));
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_req == REQ_PATTERN && store) begin
      pat_star[len_base[IDX_W-1:0]] <= (in_ch == CH_STAR);
      pat_any[len_base[IDX_W-1:0]]  <= (in_ch == CH_ANY);
      pat_fold[len_base[IDX_W-1:0]] <= fold_char(in_ch);
    end
  end

  assign step.fresh   = !text_open;
  assign step.consume = !in_none;
  assign step.ch      = in_ch;

  gwm_nfa #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_nfa (
    .cur_set  (pos_set),
    .pat_star (pat_star),
    .pat_any  (pat_any),
    .pat_fold (pat_fold),
    .pat_valid(pat_valid),
    .step     (step),
    .nxt_set  (pos_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      length    <= '0;
      closed    <= 1'b1;
      ovf       <= 1'b0;
      text_open <= 1'b0;
      pos_set   <= '0;
    end else if (advance) begin
      if (in_req == REQ_PATTERN) begin
        text_open <= 1'b0;
        length    <= length_next;
        ovf       <= ovf_next;
        closed    <= in_last;
      end else begin
        pos_set   <= pos_next;
        text_open <= !in_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emits) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emits) begin
      out_matched <= pos_next[length] && !ovf;
      out_ovf     <= ovf;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'b0, out_ovf, out_matched};

  // overflow can only be flagged once the pattern store is full
  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    ovf |-> length == LEN_W'(N))
    else $error("overflow flagged with pattern store not full");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    length <= LEN_W'(N))
    else $error("pattern length beyond capacity");

  a_ovf_no_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_matched && out_ovf))
    else $error("match reported on an overflowed pattern");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_req) && $stable(in_last))
    else $error("stalled input register lost its transaction");

  a_accept_load: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> in_valid)
    else $error("accepted transaction not held in input register");

endmodule

### dv/tb_glob_wildcard_matcher.sv
// testbench for the glob matcher: directed and random pattern/text streams against a predictor
module tb_glob_wildcard_matcher;
  import gwm_pkg::*;

  localparam int PAT_CAP    = 32;
  localparam int RAND_ITEMS = 750;

  typedef struct packed {
    logic matched;
    logic overflow;
  } verdict_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = '0;    // char_in
  logic [1:0] s_tuser = '0;    // req_type, no_char
  logic       s_tlast = 1'b0;  // last
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;         // matched, pattern_overflow, zero fill

  // predictor state
  logic [7:0]       pat_mem [PAT_CAP];
  int               pat_len = 0;
  logic             pat_closed = 1'b1;
  logic             pat_ovf = 1'b0;
  logic             txt_open = 1'b0;
  logic [PAT_CAP:0] reach = '0;
  verdict_t         verdict_q[$];
  verdict_t         want;

  logic [7:0] run_buf[$];
  logic [7:0] pat_src[$];
  int         items_sent = 0;
  int         results_seen = 0;
  int         mismatch_count = 0;
  logic       no_idle = 1'b0;

  glob_wildcard_matcher #(.MAX_PATTERN(PAT_CAP)) DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #4 clk = ~clk;

  initial begin
    #4000000;
    $display("FAILED: results differ");
    $finish;
  end

  task automatic note_mismatch(input string msg);
    if (mismatch_count < 100) begin
      $display("mismatch at result %0d: %s", results_seen, msg);
    end
    mismatch_count++;
  endtask

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
  endfunction

  // a reached star also reaches the position after it
  function automatic logic [PAT_CAP:0] follow_stars(input logic [PAT_CAP:0] s);
    for (int i = 0; i < pat_len; i++) begin
      if (s[i] && pat_mem[i] == CH_STAR) s[i+1] = 1'b1;
    end
    return s;
  endfunction

  task automatic advance_matcher(input logic req, input logic [7:0] ch, input logic none,
                                 input logic fin);
    logic [PAT_CAP:0] nxt;
    verdict_t         v;
    if (req == REQ_PATTERN) begin
      txt_open = 1'b0;
      if (pat_closed) begin
        pat_len = 0;
        pat_ovf = 1'b0;
        pat_closed = 1'b0;
      end
      if (!none) begin
        if (pat_len < PAT_CAP) begin
          pat_mem[pat_len] = ch;
          pat_len++;
        end else begin
          pat_ovf = 1'b1;
        end
      end
      if (fin) pat_closed = 1'b1;
    end else begin
      if (!txt_open) begin
        reach = follow_stars({{PAT_CAP{1'b0}}, 1'b1});
        txt_open = 1'b1;
      end
      if (!none) begin
        nxt = '0;
        for (int i = 0; i < pat_len; i++) begin
          if (reach[i]) begin
            if (pat_mem[i] == CH_STAR) nxt[i] = 1'b1;
            else if (pat_mem[i] == CH_ANY || to_lower(pat_mem[i]) == to_lower(ch))
              nxt[i+1] = 1'b1;
          end
        end
        reach = follow_stars(nxt);
      end
      if (fin) begin
        txt_open = 1'b0;
        v.matched = reach[pat_len] && !pat_ovf;
        v.overflow = pat_ovf;
        verdict_q = {verdict_q, v};
      end
    end
  endtask

  // predict on accepted input, check accepted output
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) advance_matcher(s_tuser[0], s_tdata, s_tuser[1], s_tlast);
      if (m_tvalid && m_tready) begin
        if (verdict_q.size() == 0) begin
          note_mismatch($sformatf("unexpected result %b", m_tdata[1:0]));
        end else begin
          want = verdict_q.pop_front();
          if (m_tdata[0] !== want.matched)
            note_mismatch($sformatf("matched %b, want %b", m_tdata[0], want.matched));
          if (m_tdata[1] !== want.overflow)
            note_mismatch($sformatf("pattern_overflow %b, want %b", m_tdata[1], want.overflow));
        end
        results_seen++;
      end
    end
  end

  always @(negedge clk) begin
    m_tready <= no_idle || ($urandom_range(0, 99) >= 31);
  end

  task automatic send_item(input logic req, input logic [7:0] ch, input logic none,
                           input logic fin);
    @(negedge clk);
    while (!no_idle && $urandom_range(0, 99) < 31) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= ch;
    s_tuser <= {none, req};
    s_tlast <= fin;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  task automatic go_quiet();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  // sends run_buf as one pattern or text, an empty run as a single no-byte transaction
  task automatic send_run(input logic req);
    if (run_buf.size() == 0) begin
      send_item(req, 8'($urandom_range(0, 255)), 1'b1, 1'b1);
    end else begin
      foreach (run_buf[i]) begin
        if ($urandom_range(0, 99) < 5) send_item(req, 8'($urandom_range(0, 255)), 1'b1, 1'b0);
        send_item(req, run_buf[i], 1'b0, i == run_buf.size() - 1);
      end
    end
  endtask

  task automatic load_str(input string s);
    run_buf.delete();
    for (int i = 0; i < s.len(); i++) run_buf = {run_buf, s[i]};
  endtask

  task automatic test_empty_strings();
    load_str("");   send_run(REQ_PATTERN);
    load_str("");   send_run(REQ_TEXT);
    load_str("x");  send_run(REQ_TEXT);
    load_str("*");  send_run(REQ_PATTERN);
    load_str("");   send_run(REQ_TEXT);
    load_str("zz"); send_run(REQ_TEXT);
  endtask

  task automatic test_wildcards();
    load_str("a?c*d");  send_run(REQ_PATTERN);
    load_str("abcd");   send_run(REQ_TEXT);
    load_str("AxC--D"); send_run(REQ_TEXT);
    load_str("abd");    send_run(REQ_TEXT);
  endtask

  // neighbors of the letter range must not fold
  task automatic test_case_folding();
    load_str("Q[@z"); send_run(REQ_PATTERN);
    load_str("q[@Z"); send_run(REQ_TEXT);
    load_str("q{@z"); send_run(REQ_TEXT);
    load_str("q[`z"); send_run(REQ_TEXT);
  endtask

  task automatic test_byte_extremes();
    run_buf = '{8'h00, 8'hFF}; send_run(REQ_PATTERN);
    send_run(REQ_TEXT);
    run_buf = '{8'hFF, 8'h00}; send_run(REQ_TEXT);
  endtask

  task automatic test_overflow();
    run_buf.delete();
    repeat (PAT_CAP) run_buf = {run_buf, CH_STAR};
    run_buf = {run_buf, 8'h78};
    send_run(REQ_PATTERN);
    load_str("a"); send_run(REQ_TEXT);
    load_str("a"); send_run(REQ_PATTERN);
    load_str("A"); send_run(REQ_TEXT);
  endtask

  task automatic test_pattern_abort();
    load_str("ab"); send_run(REQ_PATTERN);
    send_item(REQ_TEXT, 8'h61, 1'b0, 1'b0);
    send_item(REQ_PATTERN, 8'h63, 1'b0, 1'b1);
    load_str("c"); send_run(REQ_TEXT);
  endtask

  // text while the pattern is still open, then the pattern grows
  task automatic test_open_pattern();
    send_item(REQ_PATTERN, 8'h68, 1'b0, 1'b0);
    send_item(REQ_PATTERN, 8'h69, 1'b0, 1'b0);
    load_str("HI"); send_run(REQ_TEXT);
    send_item(REQ_PATTERN, CH_STAR, 1'b0, 1'b1);
    load_str("hiya"); send_run(REQ_TEXT);
  endtask

  function automatic logic [7:0] pick_pattern_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return CH_STAR;
    if (r < 40) return CH_ANY;
    if (r < 85) return 8'(8'h41 + $urandom_range(0, 25)) | 8'($urandom_range(0, 1) << 5);
    return 8'($urandom_range(0, 255));
  endfunction

  // most texts follow the pattern with random case, star runs and a few wrong bytes
  task automatic build_text();
    logic [7:0] b;
    run_buf.delete();
    if ($urandom_range(0, 99) < 15) begin
      repeat ($urandom_range(0, 6)) run_buf = {run_buf, 8'($urandom_range(0, 255))};
    end else begin
      foreach (pat_src[i]) begin
        b = pat_src[i];
        if (b == CH_STAR) begin
          repeat ($urandom_range(0, 3)) run_buf = {run_buf, 8'(8'h61 + $urandom_range(0, 25))};
        end else if (b == CH_ANY) begin
          run_buf = {run_buf, 8'($urandom_range(0, 255))};
        end else if ($urandom_range(0, 99) < 8) begin
          run_buf = {run_buf, 8'($urandom_range(0, 255))};
        end else begin
          if ((b | 8'h20) >= 8'h61 && (b | 8'h20) <= 8'h7A && $urandom_range(0, 1))
            b = b ^ 8'h20;
          run_buf = {run_buf, b};
        end
      end
    end
  endtask

  task automatic test_random_traffic();
    int start;
    int len;
    start = items_sent;
    while (items_sent - start < RAND_ITEMS) begin
      no_idle = (items_sent - start >= 350) && (items_sent - start < 500);
      if ($urandom_range(0, 99) < 12) begin
        send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                  $urandom_range(0, 9) == 0, $urandom_range(0, 2) == 0);
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 36) : $urandom_range(0, 7);
        pat_src.delete();
        repeat (len) pat_src = {pat_src, pick_pattern_byte()};
        run_buf = pat_src;
        send_run(REQ_PATTERN);
        repeat ($urandom_range(1, 4)) begin
          build_text();
          send_run(REQ_TEXT);
        end
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    int       waited;
    verdict_t left;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_empty_strings();
    test_wildcards();
    test_case_folding();
    test_byte_extremes();
    test_overflow();
    test_pattern_abort();
    test_open_pattern();
    test_random_traffic();
    go_quiet();
    waited = 0;
    while (verdict_q.size() != 0 && waited < 10000) begin
      @(negedge clk);
      waited++;
    end
    repeat (8) @(negedge clk);
    while (verdict_q.size() != 0) begin
      left = verdict_q.pop_front();
      note_mismatch($sformatf("missing result, want %b%b", left.overflow, left.matched));
    end
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
